FILE: sv/rcn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcn_pkg: shared types and constants of the chromaticity normaliser
// Widths of the channel sum, the partial remainders and the quotients, the
// payload that moves down the divider chain, and the share saturation.
// ----------------------------------------------------------------------------
package rcn_pkg;

  // Fraction bits of the shares
  localparam int FRAC_BITS = 10;

  // Field widths
  localparam int CHAN_W  = 8;
  localparam int PIXEL_W = 3 * CHAN_W;
  localparam int SHARE_W = 11;
  localparam int SUM_W   = CHAN_W + 2;
  localparam int REM_W   = SUM_W + 1;
  localparam int Q_W     = FRAC_BITS + 1;
  localparam int QX_W    = (Q_W > SHARE_W) ? Q_W : SHARE_W;

  // One cell per quotient bit
  localparam int NUM_CELLS = Q_W;

  // Largest share the field can carry, and the value of one
  localparam int SHARE_MAX = (1 << SHARE_W) - 1;
  localparam int SHARE_ONE = 1 << FRAC_BITS;

  // Port widths, padded to whole bytes
  localparam int S_TDATA_W = ((PIXEL_W + 7) / 8) * 8;
  localparam int M_TDATA_W = ((2 * SHARE_W + 7) / 8) * 8;

  // Payload carried from cell to cell
  typedef struct packed {
    logic [REM_W-1:0] rem_r;
    logic [REM_W-1:0] rem_g;
    logic [Q_W-1:0]   q_r;
    logic [Q_W-1:0]   q_g;
    logic [SUM_W-1:0] sum;
    logic             zero;
  } rcn_lane_t;

  // Clamp a quotient to the share field
  function automatic logic [SHARE_W-1:0] sat_share(input logic [Q_W-1:0] q);
    logic [QX_W-1:0] qx;
    qx = QX_W'(q);
    if (qx > QX_W'(SHARE_MAX)) begin
      return SHARE_W'(SHARE_MAX);
    end else begin
      return qx[SHARE_W-1:0];
    end
  endfunction

endpackage

FILE: sv/rcn_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcn_cell: one restoring-division step for both shares
// Trial-subtracts the channel sum from the red and green remainders, shifts
// in one quotient bit each and registers the result for the next cell.
// ----------------------------------------------------------------------------
module rcn_cell (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  rcn_pkg::rcn_lane_t in_lane,
  output logic              out_valid,
  input  logic              out_ready,
  output rcn_pkg::rcn_lane_t out_lane
);

  logic                     ge_r;
  logic                     ge_g;
  logic [rcn_pkg::REM_W-1:0] diff_r;
  logic [rcn_pkg::REM_W-1:0] diff_g;
  logic [rcn_pkg::REM_W-1:0] sum_x;
  rcn_pkg::rcn_lane_t       lane_next;

  // Take a transaction whenever this stage is empty or drains this cycle
  assign in_ready = !out_valid || out_ready;

  // Compare, subtract and shift for both lanes
  always_comb begin
    sum_x  = rcn_pkg::REM_W'(in_lane.sum);
    ge_r   = in_lane.rem_r >= sum_x;
    ge_g   = in_lane.rem_g >= sum_x;
    diff_r = ge_r ? (in_lane.rem_r - sum_x) : in_lane.rem_r;
    diff_g = ge_g ? (in_lane.rem_g - sum_x) : in_lane.rem_g;
    lane_next       = in_lane;
    lane_next.rem_r = {diff_r[rcn_pkg::REM_W-2:0], 1'b0};
    lane_next.rem_g = {diff_g[rcn_pkg::REM_W-2:0], 1'b0};
    lane_next.q_r   = {in_lane.q_r[rcn_pkg::Q_W-2:0], ge_r};
    lane_next.q_g   = {in_lane.q_g[rcn_pkg::Q_W-2:0], ge_g};
  end

  // Hold the stage valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  // Advance the payload
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_lane <= lane_next;
    end
  end

endmodule

FILE: sv/rcn_out.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcn_out: result register of the chromaticity normaliser
// Clamps the quotients, forces both shares to zero for a black pixel and
// holds the result until the receiver takes it.
// ----------------------------------------------------------------------------
module rcn_out (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  rcn_pkg::rcn_lane_t            in_lane,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rcn_pkg::SHARE_W-1:0]   red_share,
  output logic [rcn_pkg::SHARE_W-1:0]   green_share,
  output logic                          zero_sum
);

  logic [rcn_pkg::SHARE_W-1:0] red_next;
  logic [rcn_pkg::SHARE_W-1:0] green_next;

  assign in_ready = !out_valid || out_ready;

  // Clamp, then drop the shares of a black pixel
  always_comb begin
    if (in_lane.zero) begin
      red_next   = '0;
      green_next = '0;
    end else begin
      red_next   = rcn_pkg::sat_share(in_lane.q_r);
      green_next = rcn_pkg::sat_share(in_lane.q_g);
    end
  end

  // Hold the result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  // Load the result
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      red_share   <= red_next;
      green_share <= green_next;
      zero_sum    <= in_lane.zero;
    end
  end

endmodule

FILE: sv/rgb_chromaticity_normalizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_chromaticity_normalizer: normalised rg chromaticity of RGB pixels
// Splits each pixel into R, G and B and returns R/sum and G/sum as unsigned
// truncated fractions, with a flag for a black pixel.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries one packed pixel per transaction (blue in the
//   lowest byte, then green, then red). The master stream returns one result
//   per pixel, in order: red_share and green_share in tdata with FRAC_BITS
//   fraction bits, zero_sum in tuser. A black pixel gives both shares zero
//   and zero_sum high.
//   A pixel passes through the row of division cells, one per quotient
//   bit, and then through the result register.
//   Throughput is one pixel per clock while the receiver takes results;
//   the cells work on different pixels at once.
//   Each cell and the result register take a new transaction when empty or
//   draining, so while the receiver stalls the block keeps accepting pixels
//   until the row is full, and then holds s_axis_tready low. Nothing is
//   lost or repeated.
//   Synchronous reset empties the row and the result register; there is no
//   other state.
// ----------------------------------------------------------------------------
module rgb_chromaticity_normalizer (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [23:0] pixel
  input  logic [rcn_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [10:0] red_share, [21:11] green_share, [23:22] zero padding
  output logic [rcn_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  // [0] zero_sum
  output logic                            m_axis_tuser
);

  rcn_pkg::rcn_lane_t                lane  [rcn_pkg::NUM_CELLS+1];
  logic [rcn_pkg::NUM_CELLS:0]       valid;
  logic [rcn_pkg::NUM_CELLS:0]       ready;
  logic [rcn_pkg::CHAN_W-1:0]        red;
  logic [rcn_pkg::CHAN_W-1:0]        green;
  logic [rcn_pkg::CHAN_W-1:0]        blue;
  logic [rcn_pkg::SUM_W-1:0]         sum;
  logic [rcn_pkg::SHARE_W-1:0]       red_share;
  logic [rcn_pkg::SHARE_W-1:0]       green_share;

  // Unpack the pixel and form the channel sum
  always_comb begin
    blue  = s_axis_tdata[rcn_pkg::CHAN_W-1:0];
    green = s_axis_tdata[2*rcn_pkg::CHAN_W-1:rcn_pkg::CHAN_W];
    red   = s_axis_tdata[3*rcn_pkg::CHAN_W-1:2*rcn_pkg::CHAN_W];
    sum   = rcn_pkg::SUM_W'(red) + rcn_pkg::SUM_W'(green) + rcn_pkg::SUM_W'(blue);
    lane[0].rem_r = rcn_pkg::REM_W'(red);
    lane[0].rem_g = rcn_pkg::REM_W'(green);
    lane[0].q_r   = '0;
    lane[0].q_g   = '0;
    lane[0].sum   = sum;
    lane[0].zero  = (sum == '0);
  end

  assign valid[0]      = s_axis_tvalid;
  assign s_axis_tready = ready[0];

  // Row of division cells, one quotient bit each
  for (genvar i = 0; i < rcn_pkg::NUM_CELLS; i++) begin : g_cell
    rcn_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (valid[i]),
      .in_ready  (ready[i]),
      .in_lane   (lane[i]),
      .out_valid (valid[i+1]),
      .out_ready (ready[i+1]),
      .out_lane  (lane[i+1])
    );
  end

  // Result register
  rcn_out u_out (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (valid[rcn_pkg::NUM_CELLS]),
    .in_ready    (ready[rcn_pkg::NUM_CELLS]),
    .in_lane     (lane[rcn_pkg::NUM_CELLS]),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .red_share   (red_share),
    .green_share (green_share),
    .zero_sum    (m_axis_tuser)
  );

  assign m_axis_tdata = rcn_pkg::M_TDATA_W'({green_share, red_share});

endmodule

FILE: sv/rcn_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcn_checker: port-level checks of the chromaticity normaliser
// Watches the master stream for reset behaviour, held results and the
// range of the shares, and the slave stream for back-pressure.
// ----------------------------------------------------------------------------
module rcn_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [rcn_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input logic                          m_axis_tuser
);

  logic [rcn_pkg::SHARE_W-1:0] red_share;
  logic [rcn_pkg::SHARE_W-1:0] green_share;
  logic [rcn_pkg::SHARE_W+1:0] share_total;

  assign red_share   = m_axis_tdata[rcn_pkg::SHARE_W-1:0];
  assign green_share = m_axis_tdata[2*rcn_pkg::SHARE_W-1:rcn_pkg::SHARE_W];
  assign share_total = (rcn_pkg::SHARE_W+2)'(red_share) + (rcn_pkg::SHARE_W+2)'(green_share);

  // No result straight after reset
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !m_axis_tvalid)
    else $error("result valid straight after reset");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // A black pixel carries zero shares
  a_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> red_share == '0 && green_share == '0)
    else $error("black pixel with non-zero share");

  // Red and green together never exceed one
  a_total: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> share_total <= (rcn_pkg::SHARE_W+2)'(rcn_pkg::SHARE_ONE))
    else $error("shares add up to more than one");

  // A ready receiver never backs up the sender
  a_flow: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && m_axis_tready |-> s_axis_tready)
    else $error("slave side stalled while the receiver was ready");

endmodule

bind rgb_chromaticity_normalizer rcn_checker u_rcn_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
